// ===== sv/esc_pkg.sv =====
`timescale 1ns / 1ps

package esc_pkg;

    // compensation constants
    localparam logic [63:0] PRESS_T_OFFSET = 64'd128000;
    localparam logic [63:0] PRESS_RAW_BASE = 64'd1048576;
    localparam logic [63:0] PRESS_SCALE    = 64'd3125;
    localparam logic [63:0] PRESS_P1_BIAS  = 64'd140737488355328;
    localparam logic [31:0] HUM_T_OFFSET   = 32'd76800;
    localparam logic [31:0] HUM_CLAMP_MAX  = 32'd419430400;
    localparam logic [31:0] HUM_BIAS_A     = 32'd2097152;
    localparam logic [31:0] HUM_ROUND_A    = 32'd16384;
    localparam logic [31:0] HUM_BIAS_B     = 32'd32768;
    localparam logic [31:0] HUM_ROUND_B    = 32'd8192;
    localparam logic [31:0] TEMP_ROUND     = 32'd128;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_TEMP     = 3'd0,
        CFG_PRESS_LO = 3'd1,
        CFG_PRESS_HI = 3'd2,
        CFG_PRESS_P9 = 3'd3,
        CFG_HUM      = 3'd4
    } t_cfg_idx;

    // one raw sample triple
    typedef struct packed {
        logic [19:0] raw_temperature;
        logic [19:0] raw_pressure;
        logic [15:0] raw_humidity;
    } t_item;

    // calibration coefficient registers
    typedef struct packed {
        logic [47:0] temp;
        logic [63:0] press_lo;
        logic [63:0] press_hi;
        logic [15:0] press_p9;
        logic [63:0] hum;
    } t_coeffs;

endpackage

// ===== sv/esc_front.sv =====
`timescale 1ns / 1ps

module esc_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  esc_pkg::t_item i_item,
    output logic           o_item_valid,
    output esc_pkg::t_item o_item,
    input  logic           i_pop
);

    esc_pkg::t_item r_mem [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;
    logic           w_push;

    // two-entry request queue toward the sequencer
    assign o_ready      = (r_cnt != 2'd2);
    assign w_push       = i_valid && o_ready;
    assign o_item_valid = (r_cnt != 2'd0);
    assign o_item       = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_item;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, i_pop};
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count out of range");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_cnt != 2'd0) else $error("pop from empty queue");

endmodule

// ===== sv/esc_mul.sv =====
`timescale 1ns / 1ps

module esc_mul (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_go,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    output logic        o_done,
    output logic [63:0] o_prod
);

    logic [1:0]  r_ph;
    logic [63:0] r_acc;
    logic [31:0] w_x;
    logic [31:0] w_y;
    logic [63:0] w_pp;

    // low 64 bits of the product from three 32x32 partial products
    always_comb begin
        unique case (r_ph)
            2'd0: begin
                w_x = i_a[31:0];
                w_y = i_b[31:0];
            end
            2'd1: begin
                w_x = i_a[31:0];
                w_y = i_b[63:32];
            end
            default: begin
                w_x = i_a[63:32];
                w_y = i_b[31:0];
            end
        endcase
    end

    assign w_pp   = w_x * w_y;
    assign o_done = i_go && (r_ph == 2'd3);
    assign o_prod = r_acc;

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            unique case (r_ph)
                2'd0:    r_acc <= w_pp;
                2'd1:    r_acc <= r_acc + {w_pp[31:0], 32'd0};
                2'd2:    r_acc <= r_acc + {w_pp[31:0], 32'd0};
                default: r_acc <= r_acc;
            endcase
        end
        if (!i_rst_n) begin
            r_ph <= 2'd0;
        end else if (i_go) begin
            r_ph <= r_ph + 2'd1;
        end else begin
            r_ph <= 2'd0;
        end
    end

endmodule

// ===== sv/esc_div.sv =====
`timescale 1ns / 1ps

module esc_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_go,
    input  logic [63:0] i_num,
    input  logic [63:0] i_den,
    output logic        o_done,
    output logic [63:0] o_quot
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } t_state;

    t_state      r_state;
    logic [5:0]  r_cnt;
    logic [63:0] r_q;
    logic [63:0] r_r;
    logic [63:0] r_d;
    logic        r_neg;
    logic [64:0] w_t;
    logic [64:0] w_diff;
    logic        w_ge;

    // restoring division, one quotient bit a cycle
    assign w_t    = {r_r, r_q[63]};
    assign w_diff = w_t - {1'b0, r_d};
    assign w_ge   = (w_t >= {1'b0, r_d});
    assign o_done = (r_state == ST_DONE);
    assign o_quot = r_neg ? (64'd0 - r_q) : r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= 6'd0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_go) begin
                        r_q     <= i_num[63] ? (64'd0 - i_num) : i_num;
                        r_d     <= i_den[63] ? (64'd0 - i_den) : i_den;
                        r_r     <= 64'd0;
                        r_neg   <= i_num[63] ^ i_den[63];
                        r_cnt   <= 6'd0;
                        r_state <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    r_r     <= w_ge ? w_diff[63:0] : w_t[63:0];
                    r_q     <= {r_q[62:0], w_ge};
                    r_cnt   <= r_cnt + 6'd1;
                    if (r_cnt == 6'd63) begin
                        r_state <= ST_DONE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== sv/esc_back.sv =====
`timescale 1ns / 1ps

module esc_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  esc_pkg::t_coeffs i_coeffs,
    input  logic             i_item_valid,
    input  esc_pkg::t_item   i_item,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [31:0]      o_temperature_centi,
    output logic [31:0]      o_pressure_q24_8,
    output logic [16:0]      o_humidity_q22_10,
    output logic             o_pressure_div_zero
);

    typedef enum logic [4:0] {
        S_IDLE, S_T1, S_T2, S_T3,
        S_P1, S_P2, S_P3, S_P4, S_P5, S_P6, S_P7, S_DIV, S_P8, S_P9, S_P10,
        S_H1, S_H2, S_H3, S_H4, S_H5, S_H6, S_H7, S_H8, S_OUT
    } t_state;

    function automatic logic [63:0] sx32(input logic [31:0] x);
        return {{32{x[31]}}, x};
    endfunction

    function automatic logic [63:0] sx16(input logic [15:0] x);
        return {{48{x[15]}}, x};
    endfunction

    t_state      r_state;
    logic [19:0] r_at;
    logic [19:0] r_ap;
    logic [15:0] r_ah;
    logic [31:0] r_v1;
    logic [31:0] r_x32;
    logic [31:0] r_tf;
    logic [31:0] r_temp;
    logic [63:0] r_aa;
    logic [63:0] r_b;
    logic [63:0] r_den;
    logic [63:0] r_num;
    logic [63:0] r_q;
    logic [63:0] r_m;
    logic [31:0] r_press;
    logic        r_divz;
    logic [31:0] r_hx;
    logic [31:0] r_he;
    logic [31:0] r_hf;
    logic [31:0] r_hv;
    logic [16:0] r_hum;
    logic        r_out_valid;
    logic [31:0] r_out_temp;
    logic [31:0] r_out_press;
    logic [16:0] r_out_hum;
    logic        r_out_divz;

    // coefficient fields
    logic [31:0] w_t1, w_t2, w_t3;
    logic [63:0] w_p1, w_p2, w_p3, w_p4, w_p5, w_p6, w_p7, w_p8, w_p9;
    logic [31:0] w_h1, w_h2, w_h3, w_h4, w_h5, w_h6;

    assign w_t1 = {16'd0, i_coeffs.temp[15:0]};
    assign w_t2 = {{16{i_coeffs.temp[31]}}, i_coeffs.temp[31:16]};
    assign w_t3 = {{16{i_coeffs.temp[47]}}, i_coeffs.temp[47:32]};
    assign w_p1 = {48'd0, i_coeffs.press_lo[15:0]};
    assign w_p2 = sx16(i_coeffs.press_lo[31:16]);
    assign w_p3 = sx16(i_coeffs.press_lo[47:32]);
    assign w_p4 = sx16(i_coeffs.press_lo[63:48]);
    assign w_p5 = sx16(i_coeffs.press_hi[15:0]);
    assign w_p6 = sx16(i_coeffs.press_hi[31:16]);
    assign w_p7 = sx16(i_coeffs.press_hi[47:32]);
    assign w_p8 = sx16(i_coeffs.press_hi[63:48]);
    assign w_p9 = sx16(i_coeffs.press_p9);
    assign w_h1 = {24'd0, i_coeffs.hum[7:0]};
    assign w_h2 = {{16{i_coeffs.hum[23]}}, i_coeffs.hum[23:8]};
    assign w_h3 = {24'd0, i_coeffs.hum[31:24]};
    assign w_h4 = {{20{i_coeffs.hum[43]}}, i_coeffs.hum[43:32]};
    assign w_h5 = {{20{i_coeffs.hum[55]}}, i_coeffs.hum[55:44]};
    assign w_h6 = {{24{i_coeffs.hum[63]}}, i_coeffs.hum[63:56]};

    // shared multiplier and divider
    logic        w_mul_go;
    logic        w_mul_done;
    logic [63:0] w_mul_a;
    logic [63:0] w_mul_b;
    logic [63:0] w_prod;
    logic [31:0] w_p32;
    logic        w_div_go;
    logic        w_div_done;
    logic [63:0] w_quot;

    assign w_mul_go = (r_state != S_IDLE) && (r_state != S_DIV) && (r_state != S_OUT);
    assign w_div_go = (r_state == S_DIV);
    assign w_p32    = w_prod[31:0];

    esc_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (w_mul_go),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    esc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (w_div_go),
        .i_num   (r_num),
        .i_den   (r_den),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // derived values
    logic [31:0] w_at32;
    logic [63:0] w_a0;
    logic [31:0] w_hvt;
    logic [31:0] w_tf_new;
    logic [31:0] w_tf5;
    logic [31:0] w_temp_new;
    logic [63:0] w_den_new;
    logic [63:0] w_p_raw;
    logic [63:0] w_q13;
    logic [63:0] w_pb;
    logic [63:0] w_psum;
    logic [63:0] w_pfin;
    logic [31:0] w_hx_in;
    logic [31:0] w_hv_fin;
    logic [31:0] w_hv_clamp;
    logic [31:0] w_hs;
    logic        w_out_load;

    assign w_at32     = {12'd0, r_at};
    assign w_a0       = sx32(r_tf) - esc_pkg::PRESS_T_OFFSET;
    assign w_hvt      = r_tf - esc_pkg::HUM_T_OFFSET;
    assign w_tf_new   = r_v1 + $unsigned($signed(w_p32) >>> 14);
    assign w_tf5      = (w_tf_new << 2) + w_tf_new;
    assign w_temp_new = $signed(w_tf5 + esc_pkg::TEMP_ROUND) >>> 8;
    assign w_den_new  = $signed(w_prod) >>> 33;
    assign w_p_raw    = esc_pkg::PRESS_RAW_BASE - {44'd0, r_ap};
    assign w_q13      = $signed(r_q) >>> 13;
    assign w_pb       = $signed(w_prod) >>> 19;
    assign w_psum     = r_q + r_m + w_pb;
    assign w_pfin     = $unsigned($signed(w_psum) >>> 8) + (w_p7 << 4);
    assign w_hx_in    = ({16'd0, r_ah} << 14) - (w_h4 << 20) - w_p32 + esc_pkg::HUM_ROUND_A;
    assign w_hv_fin   = r_hv - $unsigned($signed(w_p32) >>> 4);
    assign w_hs       = $signed(r_hv) >>> 15;
    assign w_out_load = (r_state == S_OUT) && (!r_out_valid || i_ready);

    // humidity clamp to the valid range
    always_comb begin
        priority if (w_hv_fin[31]) begin
            w_hv_clamp = 32'd0;
        end else if (w_hv_fin > esc_pkg::HUM_CLAMP_MAX) begin
            w_hv_clamp = esc_pkg::HUM_CLAMP_MAX;
        end else begin
            w_hv_clamp = w_hv_fin;
        end
    end

    // multiplier operands per step
    always_comb begin
        unique case (r_state)
            S_T1: begin
                w_mul_a = sx32((w_at32 >> 3) - (w_t1 << 1));
                w_mul_b = sx32(w_t2);
            end
            S_T2: begin
                w_mul_a = sx32((w_at32 >> 4) - w_t1);
                w_mul_b = sx32((w_at32 >> 4) - w_t1);
            end
            S_T3: begin
                w_mul_a = sx32(r_x32);
                w_mul_b = sx32(w_t3);
            end
            S_P1: begin
                w_mul_a = w_a0;
                w_mul_b = w_a0;
            end
            S_P2: begin
                w_mul_a = r_aa;
                w_mul_b = w_p6;
            end
            S_P3: begin
                w_mul_a = w_a0;
                w_mul_b = w_p5;
            end
            S_P4: begin
                w_mul_a = r_aa;
                w_mul_b = w_p3;
            end
            S_P5: begin
                w_mul_a = w_a0;
                w_mul_b = w_p2;
            end
            S_P6: begin
                w_mul_a = esc_pkg::PRESS_P1_BIAS + r_aa;
                w_mul_b = w_p1;
            end
            S_P7: begin
                w_mul_a = (w_p_raw << 31) - r_b;
                w_mul_b = esc_pkg::PRESS_SCALE;
            end
            S_P8: begin
                w_mul_a = w_p9;
                w_mul_b = w_q13;
            end
            S_P9: begin
                w_mul_a = r_m;
                w_mul_b = w_q13;
            end
            S_P10: begin
                w_mul_a = w_p8;
                w_mul_b = r_q;
            end
            S_H1: begin
                w_mul_a = sx32(w_h5);
                w_mul_b = sx32(w_hvt);
            end
            S_H2: begin
                w_mul_a = sx32(w_hvt);
                w_mul_b = sx32(w_h6);
            end
            S_H3: begin
                w_mul_a = sx32(w_hvt);
                w_mul_b = sx32(w_h3);
            end
            S_H4: begin
                w_mul_a = sx32(r_he);
                w_mul_b = sx32(r_hf);
            end
            S_H5: begin
                w_mul_a = sx32(r_he);
                w_mul_b = sx32(w_h2);
            end
            S_H6: begin
                w_mul_a = sx32(r_hx);
                w_mul_b = sx32(r_he);
            end
            S_H7: begin
                w_mul_a = sx32(w_hs);
                w_mul_b = sx32(w_hs);
            end
            S_H8: begin
                w_mul_a = sx32(r_he);
                w_mul_b = sx32(w_h1);
            end
            default: begin
                w_mul_a = 64'd0;
                w_mul_b = 64'd0;
            end
        endcase
    end

    assign o_pop               = (r_state == S_IDLE) && i_item_valid;
    assign o_valid             = r_out_valid;
    assign o_temperature_centi = r_out_temp;
    assign o_pressure_q24_8    = r_out_press;
    assign o_humidity_q22_10   = r_out_hum;
    assign o_pressure_div_zero = r_out_divz;

    // step sequencer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_item_valid) begin
                        r_at    <= i_item.raw_temperature;
                        r_ap    <= i_item.raw_pressure;
                        r_ah    <= i_item.raw_humidity;
                        r_state <= S_T1;
                    end
                end
                S_T1: if (w_mul_done) begin
                    r_v1    <= $signed(w_p32) >>> 11;
                    r_state <= S_T2;
                end
                S_T2: if (w_mul_done) begin
                    r_x32   <= $signed(w_p32) >>> 12;
                    r_state <= S_T3;
                end
                S_T3: if (w_mul_done) begin
                    r_tf    <= w_tf_new;
                    r_temp  <= w_temp_new;
                    r_state <= S_P1;
                end
                S_P1: if (w_mul_done) begin
                    r_aa    <= w_prod;
                    r_state <= S_P2;
                end
                S_P2: if (w_mul_done) begin
                    r_b     <= w_prod;
                    r_state <= S_P3;
                end
                S_P3: if (w_mul_done) begin
                    r_b     <= r_b + (w_prod << 17) + (w_p4 << 35);
                    r_state <= S_P4;
                end
                S_P4: if (w_mul_done) begin
                    r_aa    <= $signed(w_prod) >>> 8;
                    r_state <= S_P5;
                end
                S_P5: if (w_mul_done) begin
                    r_aa    <= r_aa + (w_prod << 12);
                    r_state <= S_P6;
                end
                S_P6: if (w_mul_done) begin
                    r_den <= w_den_new;
                    if (w_den_new == 64'd0) begin
                        r_divz  <= 1'b1;
                        r_press <= 32'd0;
                        r_state <= S_H1;
                    end else begin
                        r_divz  <= 1'b0;
                        r_state <= S_P7;
                    end
                end
                S_P7: if (w_mul_done) begin
                    r_num   <= w_prod;
                    r_state <= S_DIV;
                end
                S_DIV: if (w_div_done) begin
                    r_q     <= w_quot;
                    r_state <= S_P8;
                end
                S_P8: if (w_mul_done) begin
                    r_m     <= w_prod;
                    r_state <= S_P9;
                end
                S_P9: if (w_mul_done) begin
                    r_m     <= $signed(w_prod) >>> 25;
                    r_state <= S_P10;
                end
                S_P10: if (w_mul_done) begin
                    r_press <= w_pfin[31:0];
                    r_state <= S_H1;
                end
                S_H1: if (w_mul_done) begin
                    r_hx    <= $signed(w_hx_in) >>> 15;
                    r_state <= S_H2;
                end
                S_H2: if (w_mul_done) begin
                    r_he    <= $signed(w_p32) >>> 10;
                    r_state <= S_H3;
                end
                S_H3: if (w_mul_done) begin
                    r_hf    <= $unsigned($signed(w_p32) >>> 11) + esc_pkg::HUM_BIAS_B;
                    r_state <= S_H4;
                end
                S_H4: if (w_mul_done) begin
                    r_he    <= $unsigned($signed(w_p32) >>> 10) + esc_pkg::HUM_BIAS_A;
                    r_state <= S_H5;
                end
                S_H5: if (w_mul_done) begin
                    r_he    <= $signed(w_p32 + esc_pkg::HUM_ROUND_B) >>> 14;
                    r_state <= S_H6;
                end
                S_H6: if (w_mul_done) begin
                    r_hv    <= w_p32;
                    r_state <= S_H7;
                end
                S_H7: if (w_mul_done) begin
                    r_he    <= $signed(w_p32) >>> 7;
                    r_state <= S_H8;
                end
                S_H8: if (w_mul_done) begin
                    r_hum   <= w_hv_clamp[28:12];
                    r_state <= S_OUT;
                end
                default: begin
                    if (w_out_load) begin
                        r_out_temp  <= r_temp;
                        r_out_press <= r_press;
                        r_out_hum   <= r_hum;
                        r_out_divz  <= r_divz;
                        r_state     <= S_IDLE;
                    end
                end
            endcase
        end
    end

    a_hum_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out_hum <= 17'd102400) else $error("humidity out of range");
    a_divz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_divz) |-> r_out_press == 32'd0)
        else $error("pressure not zero on zero divisor");
    a_unit_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_mul_go && w_div_go)) else $error("multiplier and divider both active");
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_go |-> r_den != 64'd0) else $error("division by zero started");

endmodule

// ===== sv/env_sensor_compensation.sv =====
`timescale 1ns / 1ps

// Integer compensation of a raw temperature / pressure / humidity triple using
// calibration coefficients written through the configuration port. Requests
// enter a two-entry queue and are worked one at a time by a step sequencer
// built around one shared 32x32 multiplier (21 64-bit wrapping multiplies per
// request) and a radix-2 divider for the pressure quotient; when the pressure
// divisor is zero the divide and the remaining pressure steps are skipped.
// The result sits in an output register so the next request starts while the
// previous result waits to be taken.
// Coefficients must only be written while no request is in flight.
module env_sensor_compensation (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [19:0]        i_raw_temperature,
    input  logic [19:0]        i_raw_pressure,
    input  logic [15:0]        i_raw_humidity,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_temperature_centi,
    output logic [31:0]        o_pressure_q24_8,
    output logic [16:0]        o_humidity_q22_10,
    output logic               o_pressure_div_zero,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [63:0]        i_cfg_data
);

    esc_pkg::t_coeffs r_coeffs;
    esc_pkg::t_item   w_in_item;
    esc_pkg::t_item   w_q_item;
    logic             w_q_valid;
    logic             w_pop;
    logic [31:0]      w_temp;

    // coefficient registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coeffs <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                esc_pkg::CFG_TEMP:     r_coeffs.temp     <= i_cfg_data[47:0];
                esc_pkg::CFG_PRESS_LO: r_coeffs.press_lo <= i_cfg_data;
                esc_pkg::CFG_PRESS_HI: r_coeffs.press_hi <= i_cfg_data;
                esc_pkg::CFG_PRESS_P9: r_coeffs.press_p9 <= i_cfg_data[15:0];
                esc_pkg::CFG_HUM:      r_coeffs.hum      <= i_cfg_data;
                default:               r_coeffs          <= r_coeffs;
            endcase
        end
    end

    assign w_in_item.raw_temperature = i_raw_temperature;
    assign w_in_item.raw_pressure    = i_raw_pressure;
    assign w_in_item.raw_humidity    = i_raw_humidity;

    esc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_item       (w_in_item),
        .o_item_valid (w_q_valid),
        .o_item       (w_q_item),
        .i_pop        (w_pop)
    );

    esc_back u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_coeffs            (r_coeffs),
        .i_item_valid        (w_q_valid),
        .i_item              (w_q_item),
        .o_pop               (w_pop),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_temperature_centi (w_temp),
        .o_pressure_q24_8    (o_pressure_q24_8),
        .o_humidity_q22_10   (o_humidity_q22_10),
        .o_pressure_div_zero (o_pressure_div_zero)
    );

    assign o_temperature_centi = $signed(w_temp);

endmodule

// ===== tb/sv/env_sensor_compensation_test.sv =====
`timescale 1ns / 1ps

module env_sensor_compensation_test;

    localparam int CLK_HALF     = 2;
    localparam int ITEMS_PHASE  = 100;
    localparam int PHASES       = 8;
    localparam int DRAIN_CYCLES = 400;

    // idle modes of the two sides
    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle_mode;

    typedef struct packed {
        logic signed [31:0] temp;
        logic [31:0]        press;
        logic [16:0]        hum;
        logic               divz;
    } t_reading;

    // directed stimulus row, expectation used only when known
    typedef struct {
        logic [19:0] raw_t;
        logic [19:0] raw_p;
        logic [15:0] raw_h;
        bit          known;
        t_reading    reading;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [19:0] i_raw_temperature = '0;
    logic [19:0] i_raw_pressure = '0;
    logic [15:0] i_raw_humidity = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic signed [31:0] o_temperature_centi;
    logic [31:0] o_pressure_q24_8;
    logic [16:0] o_humidity_q22_10;
    logic        o_pressure_div_zero;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [63:0] i_cfg_data = '0;

    esc_pkg::t_coeffs calib = '0;
    t_reading   pending_readings[$];
    t_idle_mode idle_mode = IDLE_NONE;
    int         mismatches = 0;
    int         readings_checked = 0;
    int         div_zero_seen = 0;

    env_sensor_compensation DUT (.*);

    always #(CLK_HALF) i_clk = ~i_clk;

    // arithmetic right shifts
    function automatic logic [31:0] sra32(logic [31:0] x, int n);
        return $signed(x) >>> n;
    endfunction

    function automatic logic [63:0] sra64(logic [63:0] x, int n);
        return $signed(x) >>> n;
    endfunction

    // compensated reading for one raw triple
    function automatic t_reading compensate_reading(logic [19:0] raw_t, logic [19:0] raw_p,
                                                    logic [15:0] raw_h, esc_pkg::t_coeffs c);
        logic [31:0] at, ah, t1, t2, t3, h1, h2, h3, h4, h5, h6;
        logic [31:0] v1, v2, d, tf, v, x, y;
        logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic [63:0] a, b, p, num, ma, mb, q;
        t_reading    r;
        at = {12'd0, raw_t};
        ah = {16'd0, raw_h};
        t1 = {16'd0, c.temp[15:0]};
        t2 = {{16{c.temp[31]}}, c.temp[31:16]};
        t3 = {{16{c.temp[47]}}, c.temp[47:32]};
        p1 = {48'd0, c.press_lo[15:0]};
        p2 = {{48{c.press_lo[31]}}, c.press_lo[31:16]};
        p3 = {{48{c.press_lo[47]}}, c.press_lo[47:32]};
        p4 = {{48{c.press_lo[63]}}, c.press_lo[63:48]};
        p5 = {{48{c.press_hi[15]}}, c.press_hi[15:0]};
        p6 = {{48{c.press_hi[31]}}, c.press_hi[31:16]};
        p7 = {{48{c.press_hi[47]}}, c.press_hi[47:32]};
        p8 = {{48{c.press_hi[63]}}, c.press_hi[63:48]};
        p9 = {{48{c.press_p9[15]}}, c.press_p9};
        h1 = {24'd0, c.hum[7:0]};
        h2 = {{16{c.hum[23]}}, c.hum[23:8]};
        h3 = {24'd0, c.hum[31:24]};
        h4 = {{20{c.hum[43]}}, c.hum[43:32]};
        h5 = {{20{c.hum[55]}}, c.hum[55:44]};
        h6 = {{24{c.hum[63]}}, c.hum[63:56]};

        // fine temperature
        v1 = sra32(((at >> 3) - (t1 << 1)) * t2, 11);
        d  = (at >> 4) - t1;
        v2 = sra32(sra32(d * d, 12) * t3, 14);
        tf = v1 + v2;
        r.temp = sra32(tf * 32'd5 + esc_pkg::TEMP_ROUND, 8);

        // pressure, 64-bit wrapping
        a = {{32{tf[31]}}, tf} - esc_pkg::PRESS_T_OFFSET;
        b = a * a * p6;
        b = b + ((a * p5) << 17);
        b = b + (p4 << 35);
        a = sra64(a * a * p3, 8) + ((a * p2) << 12);
        a = sra64((esc_pkg::PRESS_P1_BIAS + a) * p1, 33);
        r.press = '0;
        r.divz  = (a == '0);
        if (!r.divz) begin
            p   = esc_pkg::PRESS_RAW_BASE - {44'd0, raw_p};
            num = ((p << 31) - b) * esc_pkg::PRESS_SCALE;
            ma  = num[63] ? -num : num;
            mb  = a[63] ? -a : a;
            q   = ma / mb;
            p   = (num[63] != a[63]) ? -q : q;
            a   = sra64(p9 * sra64(p, 13) * sra64(p, 13), 25);
            b   = sra64(p8 * p, 19);
            p   = sra64(p + a + b, 8) + (p7 << 4);
            r.press = p[31:0];
        end

        // humidity, 32-bit wrapping then clamp
        v = tf - esc_pkg::HUM_T_OFFSET;
        x = sra32((ah << 14) - (h4 << 20) - h5 * v + esc_pkg::HUM_ROUND_A, 15);
        y = sra32(sra32(v * h6, 10) * (sra32(v * h3, 11) + esc_pkg::HUM_BIAS_B), 10)
            + esc_pkg::HUM_BIAS_A;
        y = sra32(y * h2 + esc_pkg::HUM_ROUND_B, 14);
        v = x * y;
        v = v - sra32(sra32(sra32(v, 15) * sra32(v, 15), 7) * h1, 4);
        if (v[31])
            v = '0;
        else if (v > esc_pkg::HUM_CLAMP_MAX)
            v = esc_pkg::HUM_CLAMP_MAX;
        r.hum = v[28:12];
        return r;
    endfunction

    // receiver stalls
    always @(posedge i_clk) begin
        if (idle_mode == IDLE_RECEIVER || idle_mode == IDLE_BOTH)
            i_ready <= ($urandom_range(99) >= (idle_mode == IDLE_BOTH ? 27 : 80));
        else
            i_ready <= 1'b1;
    end

    // result checking against the oldest expectation
    always @(posedge i_clk) begin
        t_reading want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_readings.size() == 0) begin
                $error("result with no expectation waiting");
                mismatches++;
            end else begin
                want = pending_readings.pop_front();
                readings_checked++;
                if (o_pressure_div_zero)
                    div_zero_seen++;
                if (o_temperature_centi !== want.temp) begin
                    $error("temperature_centi expected %0d actual %0d",
                           want.temp, o_temperature_centi);
                    mismatches++;
                end
                if (o_pressure_q24_8 !== want.press) begin
                    $error("pressure_q24_8 expected %0d actual %0d",
                           want.press, o_pressure_q24_8);
                    mismatches++;
                end
                if (o_humidity_q22_10 !== want.hum) begin
                    $error("humidity_q22_10 expected %0d actual %0d",
                           want.hum, o_humidity_q22_10);
                    mismatches++;
                end
                if (o_pressure_div_zero !== want.divz) begin
                    $error("pressure_div_zero expected %0d actual %0d",
                           want.divz, o_pressure_div_zero);
                    mismatches++;
                end
            end
        end
    end

    // one sample request, expectation queued at acceptance
    task automatic send_sample(logic [19:0] raw_t, logic [19:0] raw_p, logic [15:0] raw_h,
                               bit known, t_reading reading);
        int pct;
        pct = (idle_mode == IDLE_SENDER) ? 80 : (idle_mode == IDLE_BOTH) ? 27 : 0;
        if ($urandom_range(99) < pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < pct)
                @(posedge i_clk);
        end
        i_valid           <= 1'b1;
        i_raw_temperature <= raw_t;
        i_raw_pressure    <= raw_p;
        i_raw_humidity    <= raw_h;
        do @(posedge i_clk); while (!o_ready);
        pending_readings.push_back(known ? reading
                                         : compensate_reading(raw_t, raw_p, raw_h, calib));
    endtask

    // block goes idle once every expected reading is back
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending_readings.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // one register write, valid left high for a following write
    task automatic write_reg(logic [2:0] idx, logic [63:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            esc_pkg::CFG_TEMP:     calib.temp     = data[47:0];
            esc_pkg::CFG_PRESS_LO: calib.press_lo = data;
            esc_pkg::CFG_PRESS_HI: calib.press_hi = data;
            esc_pkg::CFG_PRESS_P9: calib.press_p9 = data[15:0];
            esc_pkg::CFG_HUM:      calib.hum      = data;
            default: ;
        endcase
    endtask

    // load a full coefficient set, junk in unused upper bits
    task automatic load_calib(esc_pkg::t_coeffs c);
        write_reg(esc_pkg::CFG_TEMP, {16'($urandom_range(16'hFFFF)), c.temp});
        write_reg(esc_pkg::CFG_PRESS_LO, c.press_lo);
        write_reg(esc_pkg::CFG_PRESS_HI, c.press_hi);
        write_reg(esc_pkg::CFG_PRESS_P9,
                  {$urandom, 16'($urandom_range(16'hFFFF)), c.press_p9});
        write_reg(esc_pkg::CFG_HUM, c.hum);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic esc_pkg::t_coeffs random_calib();
        esc_pkg::t_coeffs c;
        c.temp     = {16'($urandom_range(16'hFFFF)), $urandom};
        c.press_lo = rand64();
        c.press_hi = rand64();
        c.press_p9 = 16'($urandom_range(16'hFFFF));
        c.hum      = rand64();
        return c;
    endfunction

    // run timeout
    initial begin
        #20_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        esc_pkg::t_coeffs typical, c;
        t_reading after_reset;
        t_row     rows[$];
        int       guard;
        logic [19:0] rt, rp;
        logic [15:0] rh;

        typical.temp     = {16'hFC18, 16'd26435, 16'd27504};
        typical.press_lo = {16'd2855, 16'd3024, 16'hD643, 16'd36477};
        typical.press_hi = {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140};
        typical.press_p9 = 16'd6000;
        typical.hum      = {8'd30, 12'd50, 12'd324, 8'd0, 16'd362, 8'd75};
        after_reset      = '{temp: 32'sd0, press: 32'd0, hum: 17'd0, divz: 1'b1};

        // zero coefficients give a fixed reading; the rest follow the predictor
        rows.push_back('{20'd0, 20'd0, 16'd0, 1'b1, after_reset});
        rows.push_back('{20'hFFFFF, 20'hFFFFF, 16'hFFFF, 1'b1, after_reset});
        rows.push_back('{20'hFFFFF, 20'd0, 16'h8000, 1'b1, after_reset});
        rows.push_back('{20'd0, 20'hFFFFF, 16'd1, 1'b1, after_reset});
        rows.push_back('{20'd519888, 20'd415148, 16'd30000, 1'b1, after_reset});

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[k])
            send_sample(rows[k].raw_t, rows[k].raw_p, rows[k].raw_h, rows[k].known,
                        rows[k].reading);
        wait_drained();

        // unused indexes are ignored
        for (int idx = esc_pkg::CFG_HUM + 1; idx < 8; idx++)
            write_reg(3'(idx), rand64());
        load_calib(typical);
        rows.delete();
        rows.push_back('{20'd519888, 20'd415148, 16'd30000, 1'b0, after_reset});
        rows.push_back('{20'd0, 20'd0, 16'd0, 1'b0, after_reset});
        rows.push_back('{20'hFFFFF, 20'hFFFFF, 16'hFFFF, 1'b0, after_reset});
        rows.push_back('{20'd0, 20'hFFFFF, 16'hFFFF, 1'b0, after_reset});
        rows.push_back('{20'hFFFFF, 20'd0, 16'd0, 1'b0, after_reset});
        rows.push_back('{20'd440064, 20'd300000, 16'd65535, 1'b0, after_reset});
        rows.push_back('{20'd600000, 20'd500000, 16'd10, 1'b0, after_reset});
        foreach (rows[k])
            send_sample(rows[k].raw_t, rows[k].raw_p, rows[k].raw_h, 1'b0, after_reset);
        wait_drained();

        // random phases over several coefficient sets and idle modes
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0, 1: c = typical;
                2: c = '1;
                3: c = '{temp: {16'h8000, 16'h7FFF, 16'hFFFF},
                         press_lo: {16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF},
                         press_hi: {16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF},
                         press_p9: 16'h8000,
                         hum: {8'h80, 12'h7FF, 12'h800, 8'hFF, 16'h7FFF, 8'hFF}};
                4: begin
                    c = random_calib();
                    c.press_lo[15:0] = '0;
                end
                6: begin
                    c = typical;
                    c.temp[15:0]     = 16'(c.temp[15:0] + $urandom_range(4000) - 2000);
                    c.press_hi[47:0] = c.press_hi[47:0] ^ 48'($urandom_range(16'h00FF));
                    c.hum            = c.hum ^ {8'($urandom_range(8'hFF)), 56'd0};
                end
                default: c = random_calib();
            endcase
            if (ph != 1)
                load_calib(c);
            idle_mode = t_idle_mode'(ph % 4);
            for (int n = 0; n < ITEMS_PHASE; n++) begin
                if ($urandom_range(3) != 0) begin
                    rt = 20'($urandom_range(600000, 400000));
                    rp = 20'($urandom_range(600000, 200000));
                    rh = 16'($urandom_range(50000, 15000));
                end else begin
                    rt = 20'($urandom_range(20'hFFFFF));
                    rp = 20'($urandom_range(20'hFFFFF));
                    rh = 16'($urandom_range(16'hFFFF));
                end
                send_sample(rt, rp, rh, 1'b0, after_reset);
                // sender holds off until everything is back
                if (ph == 1 && n == ITEMS_PHASE / 2)
                    wait_drained();
            end
            wait_drained();
        end

        idle_mode = IDLE_NONE;
        guard = 0;
        while (guard < DRAIN_CYCLES) begin
            @(posedge i_clk);
            guard++;
        end
        if (pending_readings.size() != 0) begin
            $error("%0d expected readings never arrived", pending_readings.size());
            mismatches++;
        end

        $display("checked %0d readings over %0d coefficient sets and four idle modes",
                 readings_checked, PHASES);
        $display("divide-by-zero pressure readings seen: %0d", div_zero_seen);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/esc_pkg.sv
sv/esc_front.sv
sv/esc_mul.sv
sv/esc_div.sv
sv/esc_back.sv
sv/env_sensor_compensation.sv
tb/sv/env_sensor_compensation_test.sv
